### design/modular_exponentiation_top_defines.svh
// Assertion macros for the modular exponentiation block.
// Used by modular_exponentiation_top; needs nothing else.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MEXP_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("implication check failed");
`define MEXP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("next-cycle check failed");
`else
`define MEXP_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define MEXP_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

### design/mexp_pkg.sv
// Shared widths, command/status types and the modular adder function.
// No dependencies.
package mexp_pkg;

   localparam int DataBits     = 64;
   localparam int ModBits      = 63;
   localparam int MulSteps     = 64;
   localparam int MulCountBits = 6;

   typedef struct packed {
      logic                start;
      logic [ModBits-1:0]  x;
      logic [DataBits-1:0] y;
      logic [ModBits-1:0]  m;
   } mexp_mul_cmd_type;

   typedef struct packed {
      logic               done;
      logic [ModBits-1:0] product;
   } mexp_mul_sts_type;

   // (a + b) mod m for a, b already below m
   function automatic logic [ModBits-1:0] add_mod(input logic [ModBits-1:0] a,
                                                  input logic [ModBits-1:0] b,
                                                  input logic [ModBits-1:0] m);
      logic [ModBits:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
         end
         return s[ModBits-1:0];
      end
   endfunction

endpackage

### design/mexp_ifs.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on mexp_pkg for field widths.
interface mexp_req_if;
   import mexp_pkg::*;
   logic                valid;
   logic                ready;
   logic [DataBits-1:0] base;
   logic [DataBits-1:0] exponent;
   logic [ModBits-1:0]  modulus;
   modport source (output valid, base, exponent, modulus, input ready);
   modport sink   (input valid, base, exponent, modulus, output ready);
endinterface

interface mexp_rsp_if;
   import mexp_pkg::*;
   logic               valid;
   logic               ready;
   logic [ModBits-1:0] power_mod;
   modport source (output valid, power_mod, input ready);
   modport sink   (input valid, power_mod, output ready);
endinterface

### design/mexp_mulmod.sv
// Shared modular multiplier: double-and-add, one bit of y per cycle.
// Depends on mexp_pkg (add_mod, command and status types).
module mexp_mulmod (
   input  logic                       clock,
   input  logic                       reset,
   input  mexp_pkg::mexp_mul_cmd_type cmd,
   output mexp_pkg::mexp_mul_sts_type sts
);
   import mexp_pkg::*;

   logic [ModBits-1:0]      acc_ff, acc_in;
   logic [ModBits-1:0]      x_ff, x_in;
   logic [DataBits-1:0]     y_ff, y_in;
   logic [ModBits-1:0]      m_ff, m_in;
   logic [MulCountBits-1:0] count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   always_comb begin
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      m_in     = m_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         acc_in   = '0;
         x_in     = cmd.x;
         y_in     = cmd.y;
         m_in     = cmd.m;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // add x on a set bit, then double x
         if (y_ff[0]) begin
            acc_in = add_mod(acc_ff, x_ff, m_ff);
         end
         x_in     = add_mod(x_ff, x_ff, m_ff);
         y_in     = y_ff >> 1;
         count_in = count_ff + 1'b1;
         if (count_ff == MulCountBits'(MulSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign sts.done    = done_ff;
   assign sts.product = acc_ff;

endmodule

### design/modular_exponentiation_top.sv
// Modular exponentiation, right-to-left square-and-multiply.
// Depends on mexp_pkg, mexp_ifs, mexp_mulmod and the defines header.
//
//   channel   direction  transfer content
//   req_chan  in         base, exponent, modulus
//   rsp_chan  out        power_mod
//
// Every modular product runs on one shared double-and-add unit: a start
// command, then 64 steps. An item costs one base reduction, then per
// exponent bit up to the top set bit one dispatch, one square and, on a
// set bit, one multiply. A zero modulus skips all arithmetic; a zero
// exponent needs only the base reduction.
// req_chan is ready only while idle; a finished result waits in the output
// register, so a new item can enter while rsp_chan stalls.
// Reset is synchronous and clears control state only.
`include "modular_exponentiation_top_defines.svh"

module modular_exponentiation_top #(
   parameter int OPERAND_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   mexp_req_if.sink   req_chan,
   mexp_rsp_if.source rsp_chan
);
   import mexp_pkg::*;

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StReduce = 3'd1;
   localparam logic [2:0] StBit    = 3'd2;
   localparam logic [2:0] StMult   = 3'd3;
   localparam logic [2:0] StSquare = 3'd4;
   localparam logic [2:0] StFinish = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [OPERAND_BITS-1:0] expo_ff, expo_in;
   logic [ModBits-1:0]      m_ff, m_in;
   logic [ModBits-1:0]      acc_ff, acc_in;
   logic [ModBits-1:0]      pw_ff, pw_in;
   logic [ModBits-1:0]      power_ff, power_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    accept;
   logic                    rsp_take;
   logic [ModBits-1:0]      one_mod;
   logic [OPERAND_BITS-1:0] expo_next;
   mexp_mul_cmd_type        mul_cmd;
   mexp_mul_sts_type        mul_sts;

   mexp_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .sts   (mul_sts)
   );

   assign req_chan.ready     = (state_ff == StIdle);
   assign accept             = req_chan.valid && req_chan.ready;
   assign rsp_take           = rsp_valid_ff && rsp_chan.ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.power_mod = power_ff;

   // 1 mod m: zero only for a modulus of one
   assign one_mod   = (req_chan.modulus == ModBits'(1)) ? '0 : ModBits'(1);
   assign expo_next = expo_ff >> 1;

   always_comb begin
      state_in     = state_ff;
      expo_in      = expo_ff;
      m_in         = m_ff;
      acc_in       = acc_ff;
      pw_in        = pw_ff;
      power_in     = power_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      mul_cmd      = '0;
      mul_cmd.m    = m_ff;

      case (state_ff)
         StIdle: begin
            if (accept) begin
               expo_in = req_chan.exponent[OPERAND_BITS-1:0];
               m_in    = req_chan.modulus;
               acc_in  = one_mod;
               if (req_chan.modulus == '0) begin
                  // out of range: answer zero, no arithmetic
                  acc_in   = '0;
                  state_in = StFinish;
               end else begin
                  // base mod m as (1 mod m) * base
                  mul_cmd.start = 1'b1;
                  mul_cmd.x     = one_mod;
                  mul_cmd.y     = DataBits'(req_chan.base[OPERAND_BITS-1:0]);
                  mul_cmd.m     = req_chan.modulus;
                  state_in      = StReduce;
               end
            end
         end
         StReduce: begin
            if (mul_sts.done) begin
               pw_in    = mul_sts.product;
               state_in = (expo_ff == '0) ? StFinish : StBit;
            end
         end
         StBit: begin
            mul_cmd.start = 1'b1;
            if (expo_ff[0]) begin
               mul_cmd.x = acc_ff;
               mul_cmd.y = DataBits'(pw_ff);
               state_in  = StMult;
            end else begin
               mul_cmd.x = pw_ff;
               mul_cmd.y = DataBits'(pw_ff);
               state_in  = StSquare;
            end
         end
         StMult: begin
            if (mul_sts.done) begin
               acc_in        = mul_sts.product;
               mul_cmd.start = 1'b1;
               mul_cmd.x     = pw_ff;
               mul_cmd.y     = DataBits'(pw_ff);
               state_in      = StSquare;
            end
         end
         StSquare: begin
            if (mul_sts.done) begin
               pw_in   = mul_sts.product;
               expo_in = expo_next;
               // stop once no set exponent bits remain
               state_in = (expo_next == '0) ? StFinish : StBit;
            end
         end
         StFinish: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_take) begin
               power_in     = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      expo_ff  <= expo_in;
      m_ff     <= m_in;
      acc_ff   <= acc_in;
      pw_ff    <= pw_in;
      power_ff <= power_in;
   end

   // a transfer in closes the input until the item is finished
   `MEXP_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_chan.ready)
   // a product only completes while the sequencer waits for one
   `MEXP_ASSERT_IMPLIES(a_done_when_waiting, clock, reset, mul_sts.done,
      (state_ff == StReduce) || (state_ff == StMult) || (state_ff == StSquare))
   // running values stay reduced while exponent bits are processed
   `MEXP_ASSERT_IMPLIES(a_reduced_operands, clock, reset, state_ff == StBit,
      (acc_ff < m_ff) && (pw_ff < m_ff))

endmodule
